@@ src/tfst_pkg.sv @@
// ----------------------------------------------------------------------------
// TCP session table package
// Shared payload types, request and status codes, and default sizes.
// ----------------------------------------------------------------------------
package tfst_pkg;

  localparam int BUCKET_BITS_DEF = 10;
  localparam int WAYS_DEF        = 4;
  localparam int MAX_WORKERS_DEF = 8;

  localparam int HANDLE_W = 12;
  localparam int QUEUE_W  = 3;
  localparam int STATUS_W = 3;
  localparam int LOAD_W   = 13;
  localparam int CFG_W    = 4;

  localparam logic [LOAD_W-1:0] LOAD_MAX = 13'd8191;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [31:0]         src_ip;
    logic [15:0]         src_port;
    logic [31:0]         dst_ip;
    logic [15:0]         dst_port;
    logic [HANDLE_W-1:0] entry_handle;
  } tfst_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [QUEUE_W-1:0]  queue_number;
    logic [HANDLE_W-1:0] handle_out;
    logic                source_is_larger;
  } tfst_rsp_t;

endpackage

@@ src/tfst_load.sv @@
// ----------------------------------------------------------------------------
// Worker load tracker
// Holds one load counter per worker, finds the least-loaded worker one
// counter per cycle with a shared compare, and adjusts counts on request.
// ----------------------------------------------------------------------------
module tfst_load #(
  parameter int MAX_WORKERS = tfst_pkg::MAX_WORKERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              scan_start,
  input  logic [tfst_pkg::CFG_W-1:0]        worker_count,
  output logic                              scan_done,
  output logic [tfst_pkg::QUEUE_W-1:0]      best,
  input  logic                              inc,
  input  logic                              dec,
  input  logic [tfst_pkg::QUEUE_W-1:0]      sel
);
  import tfst_pkg::*;

  localparam int WI_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

  logic [LOAD_W-1:0] load_r [MAX_WORKERS];
  logic [WI_W:0]     idx_r, idx_nxt;
  logic [WI_W-1:0]   best_r, best_nxt;
  logic              busy_r, busy_nxt;
  logic [WI_W:0]     active;
  logic [WI_W-1:0]   sel_i;

  // Active worker count, clamped to one up to the number of counters.
  always_comb begin
    if (worker_count == '0) begin
      active = (WI_W+1)'(1);
    end else if (32'(worker_count) > MAX_WORKERS) begin
      active = (WI_W+1)'(MAX_WORKERS);
    end else begin
      active = (WI_W+1)'(worker_count);
    end
  end

  assign sel_i = sel[WI_W-1:0];

  // Scan sequencer: one counter compared per cycle, first minimum kept.
  always_comb begin
    idx_nxt  = idx_r;
    best_nxt = best_r;
    busy_nxt = busy_r;
    if (scan_start) begin
      idx_nxt  = (WI_W+1)'(1);
      best_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (idx_r >= active || MAX_WORKERS == 1) begin
        busy_nxt = 1'b0;
      end else begin
        if (load_r[best_r] > load_r[idx_r[WI_W-1:0]]) begin
          best_nxt = idx_r[WI_W-1:0];
        end
        idx_nxt = idx_r + (WI_W+1)'(1);
      end
    end
  end

  assign scan_done = busy_r && (idx_r >= active || MAX_WORKERS == 1);
  assign best      = QUEUE_W'(best_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      best_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      best_r <= best_nxt;
    end
  end

  // Counter update: saturating increment, decrement stops at zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_WORKERS; i++) begin
        load_r[i] <= '0;
      end
    end else if (inc && load_r[sel_i] < LOAD_MAX) begin
      load_r[sel_i] <= load_r[sel_i] + LOAD_W'(1);
    end else if (dec && 32'(sel) < MAX_WORKERS && load_r[sel_i] != '0) begin
      load_r[sel_i] <= load_r[sel_i] - LOAD_W'(1);
    end
  end

endmodule

@@ src/tcp_flow_session_table.sv @@
// ----------------------------------------------------------------------------
// TCP session table
// Hashed, bucketed session store with lookup, insert and remove by handle.
// ----------------------------------------------------------------------------
// Each request word is taken when in_ready is high; the block then works on
// it alone until its result word is taken. A lookup or insert visits the
// bucket's ways one at a time, each in two steps (S_RD forms the address and
// reads the entry memory, S_CHK checks the registered entry). An insert that
// finds a free way adds a scan of the worker load counters, one per cycle,
// and then writes the entry. A remove reads the entry at its handle and
// clears its valid bit if set. The block takes the next request no earlier
// than the cycle after a result word is taken. After reset the block runs a
// clearing pass over all 2**BUCKET_BITS * WAYS entries of the valid memory,
// one entry a cycle, and accepts no request meanwhile.
module tcp_flow_session_table #(
  parameter int BUCKET_BITS = tfst_pkg::BUCKET_BITS_DEF,
  parameter int WAYS        = tfst_pkg::WAYS_DEF,
  parameter int MAX_WORKERS = tfst_pkg::MAX_WORKERS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  tfst_pkg::tfst_req_t        in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output tfst_pkg::tfst_rsp_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tfst_pkg::CFG_W-1:0] cfg_data
);
  import tfst_pkg::*;

  localparam int NENT  = (1 << BUCKET_BITS) * WAYS;
  localparam int ADR_W = $clog2(NENT) > 0 ? $clog2(NENT) : 1;
  localparam int WAY_W = WAYS > 1 ? $clog2(WAYS) : 1;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_PREP   = 4'd2;
  localparam logic [3:0] S_RD     = 4'd3;
  localparam logic [3:0] S_CHK    = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_WRITE  = 4'd6;
  localparam logic [3:0] S_RMCHK  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  typedef struct packed {
    logic        valid;
    logic [31:0] big;
    logic [31:0] small_ip;
    logic [31:0] pair;
    logic [QUEUE_W-1:0] queue;
  } ent_t;

  // Entry memory and separately cleared valid memory.
  ent_t        ent_mem [NENT];
  logic        vld_mem [NENT];

  logic [3:0]  state_r, state_nxt;
  logic [ADR_W-1:0] clr_r;
  logic [CFG_W-1:0] wcnt_r;
  tfst_req_t   req_r;
  tfst_rsp_t   rsp_r;
  logic [31:0] big_r, small_r, pair_r;
  logic        srcbig_r;
  logic [ADR_W-1:0] base_r, addr_r;
  logic [WAY_W:0]   way_r;
  ent_t        rd_ent_r;
  logic        rd_vld_r;

  logic        in_fire, out_fire;
  logic        mem_we, vld_we, vld_wd;
  logic [ADR_W-1:0] vld_wa;
  logic [31:0] x;
  logic [15:0] h;
  logic        sbig;
  logic        scan_start, scan_done;
  logic [QUEUE_W-1:0] best;
  logic        ld_inc, ld_dec;
  logic [QUEUE_W-1:0] ld_sel;
  logic [ADR_W-1:0] hbase, way_addr;
  logic [ADR_W-1:0] rd_addr;

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = rsp_r;
  assign cfg_ready = 1'b1;

  // Endpoint ordering and bucket hash on the registered request word.
  assign sbig = req_r.src_ip > req_r.dst_ip;
  assign x    = big_r ^ small_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcnt_r <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      wcnt_r <= cfg_data;
    end
  end

  tfst_load #(.MAX_WORKERS(MAX_WORKERS)) u_load (
    .clk          (clk),
    .rst_n        (rst_n),
    .scan_start   (scan_start),
    .worker_count (wcnt_r),
    .scan_done    (scan_done),
    .best         (best),
    .inc          (ld_inc),
    .dec          (ld_dec),
    .sel          (ld_sel)
  );

  assign h = x[31:16] ^ x[15:0] ^ pair_r[31:16] ^ pair_r[15:0];

  // Address of the current way: the bucket base for the first way, then
  // base plus way. It is formed and read in S_RD, so the entry is in hand
  // in S_CHK together with the same address in addr_r.
  assign hbase    = ADR_W'(32'(h[BUCKET_BITS-1:0]) * WAYS);
  assign way_addr = (way_r == '0) ? hbase : base_r + ADR_W'(way_r);

  // Read address: the current way, or the handle for a remove.
  assign rd_addr = (state_r == S_RD && req_r.req_type != REQ_REMOVE) ? way_addr
                                                                      : addr_r;

  always_ff @(posedge clk) begin
    rd_ent_r <= ent_mem[rd_addr];
    rd_vld_r <= vld_mem[rd_addr];
    if (mem_we) begin
      ent_mem[addr_r] <= '{valid: 1'b1, big: big_r, small_ip: small_r,
                           pair: pair_r, queue: best};
    end
    if (vld_we) begin
      vld_mem[vld_wa] <= vld_wd;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    mem_we     = 1'b0;
    vld_we     = 1'b0;
    vld_wd     = 1'b0;
    vld_wa     = addr_r;
    scan_start = 1'b0;
    ld_inc     = 1'b0;
    ld_dec     = 1'b0;
    ld_sel     = best;
    case (state_r)
      S_CLEAR: begin
        vld_we = 1'b1;
        vld_wa = clr_r;
        if (32'(clr_r) == NENT - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) state_nxt = S_PREP;
      end
      S_PREP: begin
        if (req_r.req_type == REQ_REMOVE) begin
          if (32'(req_r.entry_handle) < NENT) state_nxt = S_RD;
          else state_nxt = S_OUT;
        end else if (req_r.req_type == REQ_LOOKUP || req_r.req_type == REQ_INSERT) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_RD: begin
        state_nxt = (req_r.req_type == REQ_REMOVE) ? S_RMCHK : S_CHK;
      end
      S_CHK: begin
        if (req_r.req_type == REQ_LOOKUP) begin
          if (rd_vld_r && rd_ent_r.big == big_r && rd_ent_r.small_ip == small_r &&
              rd_ent_r.pair == pair_r) state_nxt = S_OUT;
          else if (32'(way_r) == WAYS - 1) state_nxt = S_OUT;
          else state_nxt = S_RD;
        end else begin
          if (!rd_vld_r) begin
            scan_start = 1'b1;
            state_nxt  = S_SCAN;
          end else if (32'(way_r) == WAYS - 1) state_nxt = S_OUT;
          else state_nxt = S_RD;
        end
      end
      S_SCAN: begin
        if (scan_done) state_nxt = S_WRITE;
      end
      S_WRITE: begin
        mem_we = 1'b1;
        vld_we = 1'b1;
        vld_wd = 1'b1;
        ld_inc = 1'b1;
        state_nxt = S_OUT;
      end
      S_RMCHK: begin
        if (rd_vld_r) begin
          vld_we = 1'b1;
          ld_dec = 1'b1;
          ld_sel = rd_ent_r.queue;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + ADR_W'(1);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) req_r <= in_data;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          rsp_r   <= '{status: ST_NOT_FOUND, queue_number: '0, handle_out: '0,
                       source_is_larger: 1'b0};
        end
      end
      S_PREP: begin
        srcbig_r <= sbig;
        big_r    <= sbig ? req_r.src_ip : req_r.dst_ip;
        small_r  <= sbig ? req_r.dst_ip : req_r.src_ip;
        pair_r   <= sbig ? {req_r.src_port, req_r.dst_port}
                         : {req_r.dst_port, req_r.src_port};
        way_r    <= '0;
        if (req_r.req_type == REQ_REMOVE) begin
          addr_r <= ADR_W'(req_r.entry_handle);
          rsp_r.status <= ST_EMPTY;
        end
      end
      S_RD: begin
        if (req_r.req_type != REQ_REMOVE) begin
          if (way_r == '0) begin
            base_r <= hbase;
          end
          addr_r <= way_addr;
          rsp_r.source_is_larger <= srcbig_r;
          if (req_r.req_type == REQ_INSERT) rsp_r.status <= ST_FULL;
        end
      end
      S_CHK: begin
        way_r <= way_r + (WAY_W+1)'(1);
        if (req_r.req_type == REQ_LOOKUP && rd_vld_r && rd_ent_r.big == big_r &&
            rd_ent_r.small_ip == small_r && rd_ent_r.pair == pair_r) begin
          rsp_r.status       <= ST_FOUND;
          rsp_r.queue_number <= rd_ent_r.queue;
          rsp_r.handle_out   <= HANDLE_W'(addr_r);
        end
      end
      S_WRITE: begin
        rsp_r.status       <= ST_INSERTED;
        rsp_r.queue_number <= best;
        rsp_r.handle_out   <= HANDLE_W'(addr_r);
      end
      S_RMCHK: begin
        if (rd_vld_r) rsp_r.status <= ST_REMOVED;
      end
      default: ;
    endcase
  end

  // No request word is accepted while the block is still clearing or busy.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_data)) else $error("result changed");
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("accept while result pending");

endmodule
